FILE: rtl/b64c_pkg.sv
package b64c_pkg;

  // result kinds as they appear on the output channel
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // configuration register map, indexed by paddr[2]
  typedef enum logic {
    REG_DIRECTION = 1'b0,
    REG_OUT_CAP   = 1'b1
  } reg_e;

  localparam int          MaxRes      = 4;
  localparam int          QueueDepth  = 4;
  localparam logic [15:0] OutCapReset = 16'd65;
  localparam logic [7:0]  PadChar     = 8'h3d;
  localparam logic [7:0]  CrChar      = 8'h0d;
  localparam logic [7:0]  LfChar      = 8'h0a;

  // one result beat
  typedef struct packed {
    logic [7:0]  data;
    kind_e       kind;
    logic [15:0] count;
    logic        last;
  } res_t;

  // all results caused by one input beat
  typedef struct packed {
    logic [2:0]              n;
    res_t [MaxRes-1:0]       res;
  } cmd_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return 8'h41 + w;
    else if (v < 6'd52) return 8'h61 + w - 8'd26;
    else if (v < 6'd62) return 8'h30 + w - 8'd52;
    else if (v == 6'd62) return 8'h2b;
    else                return 8'h2f;
  endfunction

  // alphabet character to {valid, value}
  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a)      return {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7a) return {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2b)               return {1'b1, 6'd62};
    else if (c == 8'h2f)               return {1'b1, 6'd63};
    else                               return 7'd0;
  endfunction

endpackage

FILE: rtl/b64c_front.sv
module b64c_front import b64c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        direction_i,
  input  logic [15:0] out_cap_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [1:0]  phase_q, phase_d;
  logic [11:0] store_q, store_d;
  logic [3:0]  bcnt_q, bcnt_d;
  logic [15:0] nbytes_q, nbytes_d;
  logic        err_q, err_d;

  logic        accept;
  logic [2:0]  idx;
  logic [6:0]  cv;
  logic [11:0] acc;
  logic [3:0]  bsum;
  logic [3:0]  bsub;
  logic        skip;

  function automatic res_t mk(input logic [7:0] d, input kind_e k,
                              input logic [15:0] c, input logic l);
    res_t r;
    r.data  = d;
    r.kind  = k;
    r.count = c;
    r.last  = l;
    return r;
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && (idx != 3'd0);

  always_comb begin
    cmd_o    = '0;
    idx      = 3'd0;
    phase_d  = phase_q;
    store_d  = store_q;
    bcnt_d   = bcnt_q;
    nbytes_d = nbytes_q;
    err_d    = err_q;
    cv       = char_value(in_byte_i);
    acc      = {store_q[5:0], cv[5:0]};
    bsum     = bcnt_q + 4'd6;
    bsub     = bsum - 4'd8;
    skip     = (in_byte_i == PadChar) || (in_byte_i == CrChar) || (in_byte_i == LfChar);

    if (!direction_i) begin
      // encode: group position picks which bits finish a character
      if (phase_q == 2'd1) begin
        cmd_o.res[idx[1:0]] = mk(sym({store_q[1:0], in_byte_i[7:4]}), KIND_DATA, '0, 1'b0);
        idx = idx + 3'd1;
        store_d = {8'd0, in_byte_i[3:0]};
        phase_d = 2'd2;
        if (in_last_i) begin
          cmd_o.res[idx[1:0]] = mk(sym({in_byte_i[3:0], 2'b00}), KIND_DATA, '0, 1'b0);
          idx = idx + 3'd1;
          cmd_o.res[idx[1:0]] = mk(PadChar, KIND_DATA, '0, 1'b1);
          idx = idx + 3'd1;
        end
      end else if (phase_q == 2'd2) begin
        cmd_o.res[idx[1:0]] = mk(sym({store_q[3:0], in_byte_i[7:6]}), KIND_DATA, '0, 1'b0);
        idx = idx + 3'd1;
        cmd_o.res[idx[1:0]] = mk(sym(in_byte_i[5:0]), KIND_DATA, '0, in_last_i);
        idx = idx + 3'd1;
        store_d = '0;
        phase_d = 2'd0;
      end else begin
        cmd_o.res[idx[1:0]] = mk(sym(in_byte_i[7:2]), KIND_DATA, '0, 1'b0);
        idx = idx + 3'd1;
        store_d = {10'd0, in_byte_i[1:0]};
        phase_d = 2'd1;
        if (in_last_i) begin
          cmd_o.res[idx[1:0]] = mk(sym({in_byte_i[1:0], 4'b0000}), KIND_DATA, '0, 1'b0);
          idx = idx + 3'd1;
          cmd_o.res[idx[1:0]] = mk(PadChar, KIND_DATA, '0, 1'b0);
          idx = idx + 3'd1;
          cmd_o.res[idx[1:0]] = mk(PadChar, KIND_DATA, '0, 1'b1);
          idx = idx + 3'd1;
        end
      end
    end else begin
      // decode
      if (err_q) begin
        if (in_last_i) begin
          cmd_o.res[idx[1:0]] = mk(8'd0, KIND_ERR, nbytes_q, 1'b1);
          idx = idx + 3'd1;
        end
      end else if (!skip && !cv[6]) begin
        cmd_o.res[idx[1:0]] = mk(8'd0, KIND_ERR, nbytes_q, in_last_i);
        idx = idx + 3'd1;
        err_d = 1'b1;
      end else begin
        if (!skip) begin
          store_d = acc;
          if (bsum >= 4'd8 && bsum <= 4'd12) begin
            bcnt_d = bsub;
            if (nbytes_q < out_cap_i) begin
              cmd_o.res[idx[1:0]] = mk(8'(acc >> bsub), KIND_DATA, '0, 1'b0);
              idx = idx + 3'd1;
              nbytes_d = nbytes_q + 16'd1;
            end
          end else if (bsum > 4'd12) begin
            bcnt_d = 4'd0;
          end else begin
            bcnt_d = bsum;
          end
        end
        if (in_last_i) begin
          cmd_o.res[idx[1:0]] = mk(8'd0, KIND_DONE, nbytes_d, 1'b1);
          idx = idx + 3'd1;
        end
      end
    end

    cmd_o.n = idx;

    // end of stream clears all stream state
    if (in_last_i) begin
      phase_d  = '0;
      store_d  = '0;
      bcnt_d   = '0;
      nbytes_d = '0;
      err_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      store_q  <= '0;
      bcnt_q   <= '0;
      nbytes_q <= '0;
      err_q    <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      store_q  <= store_d;
      bcnt_q   <= bcnt_d;
      nbytes_q <= nbytes_d;
      err_q    <= err_d;
    end
  end

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cmd_o.n != 3'd0) && (cmd_o.n <= 3'(MaxRes)))
    else $error("command pushed with bad result count");

  a_err_only_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !direction_i) |=> !$rose(err_q))
    else $error("error hold set by an encode beat");

endmodule

FILE: rtl/b64c_fifo.sv
module b64c_fifo import b64c_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  input  logic pop_i,
  output cmd_t rdata_o,
  output logic full_o,
  output logic not_empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign rdata_o     = mem_q[rd_ptr_q];
  assign full_o      = (cnt_q == CntW'(Depth));
  assign not_empty_o = (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o)
    else $error("pop from empty queue");

endmodule

FILE: rtl/b64c_back.sv
module b64c_back import b64c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        head_i,
  input  logic        not_empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_data_o,
  output logic [1:0]  out_kind_o,
  output logic [15:0] out_count_o,
  output logic        out_last_o
);

  logic [1:0] k_q;
  logic       out_valid_q;
  res_t       out_q;
  logic       load;
  logic       last_of;

  assign load    = not_empty_i && (!out_valid_q || !out_stall_i);
  assign last_of = (({1'b0, k_q} + 3'd1) == head_i.n);
  assign pop_o   = load && last_of;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        k_q         <= last_of ? 2'd0 : k_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_i.res[k_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q.data;
  assign out_kind_o  = out_q.kind;
  assign out_count_o = out_q.count;
  assign out_last_o  = out_q.last;

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    not_empty_i |-> ({1'b0, k_q} < head_i.n))
    else $error("result index past command length");

  a_index_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (k_q == 2'd0))
    else $error("result index not rewound after pop");

endmodule

FILE: rtl/base64_stream_codec_top.sv
// streaming base64 codec, encode or decode selected by the direction register
//
// input channel: in_valid_i / in_stall_o carry one beat per byte (encode) or
// per character (decode), in_last_i closes the stream. output channel:
// out_valid_o / out_stall_i carry one result beat per cycle at most, with
// data, kind (data, done, error), decoded byte count and last flag
//
// front stage classifies each input beat and computes all results it causes
// (up to three) in the cycle it is accepted, pushing them as one command into
// a small queue; back stage plays the command out one result beat per cycle
// while the receiver does not stall; the first result of an input beat goes
// through the queue, then the back stage's output register. encode makes 4
// output beats per 3 input beats, and a final group of one or two bytes still
// makes 4 with padding; the single output register plays them out one by one
// a stalled receiver fills the queue, then in_stall_o rises until room frees
//
// registers over the apb port: byte 0 direction, byte 4 out_cap; write only
// while the codec is idle. reset sets encode mode, out_cap 65, clears stream
// state and empties the queue; no clearing pass is needed
module base64_stream_codec_top import b64c_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_data_o,
  output logic [1:0]  out_kind_o,
  output logic [15:0] out_count_o,
  output logic        out_last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        direction_q;
  logic [15:0] out_cap_q;
  logic        cfg_wr;
  reg_e        reg_sel;

  logic        full;
  logic        not_empty;
  logic        push;
  logic        pop;
  cmd_t        cmd_in;
  cmd_t        cmd_head;

  // apb register file, pready always high
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      out_cap_q   <= OutCapReset;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DIRECTION: direction_q <= pwdata[0];
        REG_OUT_CAP:   out_cap_q   <= pwdata[15:0];
        default:       direction_q <= direction_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DIRECTION: prdata = {31'd0, direction_q};
      REG_OUT_CAP:   prdata = {16'd0, out_cap_q};
      default:       prdata = '0;
    endcase
  end

  // front: accept and classify, keep stream state
  b64c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .direction_i (direction_q),
    .out_cap_i   (out_cap_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  // command queue decouples the two sides
  b64c_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wdata_i     (cmd_in),
    .pop_i       (pop),
    .rdata_o     (cmd_head),
    .full_o      (full),
    .not_empty_o (not_empty)
  );

  // back: one result beat per cycle unless the receiver stalls
  b64c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (cmd_head),
    .not_empty_i (not_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .out_kind_o  (out_kind_o),
    .out_count_o (out_count_o),
    .out_last_o  (out_last_o)
  );

endmodule
